// ----- rtl/core/cht_pkg.sv -----
// Chained hash table: shared types, sizes, codes and the key fold.
// No dependencies; every other file refers to it by scoped names.
package cht_pkg;

	localparam int BUCKET_BITS = 10;
	localparam int POOL_DEPTH  = 1024;
	localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
	localparam int NODE_BITS   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int PTR_W       = NODE_BITS + 1;   // {valid, index}
	localparam int CNT_W       = NODE_BITS + 1;
	localparam int HANDLE_W    = 10;
	localparam int FOLD_W      = 32;
	localparam int UW          = 32;              // used-bitmap word
	localparam int UW_BITS     = 5;
	localparam int USED_WORDS  = (POOL_DEPTH + UW - 1) / UW;
	localparam int UWA_BITS    = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
	localparam int CLR_N       = (NUM_BUCKETS > USED_WORDS) ? NUM_BUCKETS : USED_WORDS;
	localparam int CLR_BITS    = $clog2(CLR_N);

	localparam logic [1:0] F_LOOKUP = 2'd0;
	localparam logic [1:0] F_INSERT = 2'd1;
	localparam logic [1:0] F_REMOVE = 2'd2;

	localparam logic [1:0] S_FOUND = 2'd0;
	localparam logic [1:0] S_MISS  = 2'd1;
	localparam logic [1:0] S_NEW   = 2'd2;
	localparam logic [1:0] S_FULL  = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] key;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          status;
		logic                existed;
		logic [HANDLE_W-1:0] handle;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAD,
		ST_NODE,
		ST_SCAN,
		ST_LINK,
		ST_UNLINK,
		ST_FREE,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic                   bkt_re;
		logic                   bkt_we;
		logic [BUCKET_BITS-1:0] bkt_addr;
		logic [PTR_W-1:0]       bkt_wdata;
		logic                   node_re;
		logic [NODE_BITS-1:0]   node_raddr;
		logic                   key_we;
		logic [NODE_BITS-1:0]   key_waddr;
		logic [63:0]            key_wdata;
		logic                   nxt_we;
		logic [NODE_BITS-1:0]   nxt_waddr;
		logic [PTR_W-1:0]       nxt_wdata;
		logic                   used_re;
		logic                   used_we;
		logic [UWA_BITS-1:0]    used_addr;
		logic [UW-1:0]          used_wdata;
	} mem_req_t;

	typedef struct packed {
		logic [PTR_W-1:0] bkt_rdata;
		logic [63:0]      key_rdata;
		logic [PTR_W-1:0] nxt_rdata;
		logic [UW-1:0]    used_rdata;
	} mem_rsp_t;

	function automatic logic [BUCKET_BITS-1:0] bucket_of(input logic [63:0] key);
		logic [FOLD_W-1:0] folded;
		folded = key[31:0] ^ key[63:32];
		return folded[BUCKET_BITS-1:0];
	endfunction

endpackage

// ----- rtl/core/cht_mem.sv -----
// Chained hash table storage: bucket heads, node keys, node links, used bitmap.
// Depends on cht_pkg. All reads are registered; key and link stores add a write port.
module cht_mem (
	input  logic              clk,
	input  cht_pkg::mem_req_t req,
	output cht_pkg::mem_rsp_t rsp
);

	logic [cht_pkg::PTR_W-1:0] bkt_mem  [cht_pkg::NUM_BUCKETS];
	logic [63:0]               key_mem  [cht_pkg::POOL_DEPTH];
	logic [cht_pkg::PTR_W-1:0] nxt_mem  [cht_pkg::POOL_DEPTH];
	logic [cht_pkg::UW-1:0]    used_mem [cht_pkg::USED_WORDS];

	logic [cht_pkg::PTR_W-1:0] bkt_rd_q, nxt_rd_q;
	logic [63:0]               key_rd_q;
	logic [cht_pkg::UW-1:0]    used_rd_q;

	assign rsp = '{bkt_rdata: bkt_rd_q, key_rdata: key_rd_q, nxt_rdata: nxt_rd_q,
		used_rdata: used_rd_q};

	always_ff @(posedge clk) begin
		if (req.bkt_we) begin
			bkt_mem[req.bkt_addr] <= req.bkt_wdata;
		end
		if (req.bkt_re) begin
			bkt_rd_q <= bkt_mem[req.bkt_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.key_we) begin
			key_mem[req.key_waddr] <= req.key_wdata;
		end
		if (req.node_re) begin
			key_rd_q <= key_mem[req.node_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.nxt_we) begin
			nxt_mem[req.nxt_waddr] <= req.nxt_wdata;
		end
		if (req.node_re) begin
			nxt_rd_q <= nxt_mem[req.node_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.used_we) begin
			used_mem[req.used_addr] <= req.used_wdata;
		end
		if (req.used_re) begin
			used_rd_q <= used_mem[req.used_addr];
		end
	end

endmodule

// ----- rtl/core/cht_seq.sv -----
// Chained hash table sequencer: clear pass, chain walk with one key compare
// per cycle, free-node scan, link/unlink. Depends on cht_pkg.
module cht_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  cht_pkg::in_item_t           in_item,
	output logic                        res_valid,
	input  logic                        res_take,
	output cht_pkg::out_item_t          res_item,
	output cht_pkg::mem_req_t           req,
	input  cht_pkg::mem_rsp_t           rsp
);

	cht_pkg::state_t state_q, state_d;

	logic [1:0]                      func_q;
	logic [63:0]                     key_q;
	logic [cht_pkg::BUCKET_BITS-1:0] bkt_q;
	logic [cht_pkg::NODE_BITS-1:0]   cur_q, prev_q, alloc_q;
	logic                            has_prev_q;
	logic [cht_pkg::PTR_W-1:0]       nxt_q;
	logic [cht_pkg::CNT_W-1:0]       hint_q, count_q;
	logic [cht_pkg::UWA_BITS-1:0]    scan_w_q;
	logic [cht_pkg::CLR_BITS-1:0]    clr_q;
	cht_pkg::out_item_t              res_q;

	logic                            accept, hit, pool_full, clr_last, free_found;
	logic [cht_pkg::PTR_W-1:0]       head_ptr, next_ptr;
	logic [cht_pkg::UW-1:0]          scan_word;
	logic [cht_pkg::UW_BITS-1:0]     free_bit;
	logic [cht_pkg::NODE_BITS-1:0]   free_idx;
	logic [cht_pkg::UWA_BITS-1:0]    hint_w, cur_w;
	logic [cht_pkg::UW-1:0]          cur_bit;
	cht_pkg::state_t                 miss_state;

	assign accept    = in_valid && in_ready;
	assign head_ptr  = rsp.bkt_rdata;
	assign next_ptr  = rsp.nxt_rdata;
	assign hit       = (rsp.key_rdata == key_q);
	assign pool_full = (count_q == cht_pkg::CNT_W'(cht_pkg::POOL_DEPTH));
	assign clr_last  = (clr_q == cht_pkg::CLR_BITS'(cht_pkg::CLR_N - 1));
	assign hint_w    = cht_pkg::UWA_BITS'(hint_q >> cht_pkg::UW_BITS);
	assign cur_w     = cht_pkg::UWA_BITS'(cur_q >> cht_pkg::UW_BITS);
	assign cur_bit   = cht_pkg::UW'(1) << cht_pkg::UW_BITS'(cur_q);
	assign miss_state = (func_q == cht_pkg::F_INSERT && !pool_full) ?
		cht_pkg::ST_SCAN : cht_pkg::ST_RESP;

	// bits past the end of the pool count as used
	always_comb begin
		scan_word  = rsp.used_rdata;
		free_bit   = '0;
		free_found = 1'b0;
		for (int b = 0; b < cht_pkg::UW; b++) begin
			if (int'(scan_w_q) * cht_pkg::UW + b >= cht_pkg::POOL_DEPTH) begin
				scan_word[b] = 1'b1;
			end
		end
		for (int b = cht_pkg::UW - 1; b >= 0; b--) begin
			if (!scan_word[b]) begin
				free_bit   = cht_pkg::UW_BITS'(b);
				free_found = 1'b1;
			end
		end
	end
	assign free_idx = cht_pkg::NODE_BITS'({scan_w_q, free_bit});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cht_pkg::ST_CLEAR:  if (clr_last) state_d = cht_pkg::ST_IDLE;
			cht_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (in_item.func == cht_pkg::F_LOOKUP ||
						in_item.func == cht_pkg::F_INSERT ||
						in_item.func == cht_pkg::F_REMOVE) ?
						cht_pkg::ST_HEAD : cht_pkg::ST_RESP;
				end
			end
			cht_pkg::ST_HEAD:   state_d = head_ptr[cht_pkg::NODE_BITS] ? cht_pkg::ST_NODE : miss_state;
			cht_pkg::ST_NODE: begin
				if (hit) begin
					state_d = (func_q == cht_pkg::F_REMOVE) ? cht_pkg::ST_UNLINK : cht_pkg::ST_RESP;
				end else if (next_ptr[cht_pkg::NODE_BITS]) begin
					state_d = cht_pkg::ST_NODE;
				end else begin
					state_d = miss_state;
				end
			end
			cht_pkg::ST_SCAN:   if (free_found) state_d = cht_pkg::ST_LINK;
			cht_pkg::ST_LINK:   state_d = cht_pkg::ST_RESP;
			cht_pkg::ST_UNLINK: state_d = cht_pkg::ST_FREE;
			cht_pkg::ST_FREE:   state_d = cht_pkg::ST_RESP;
			cht_pkg::ST_RESP:   if (res_take) state_d = cht_pkg::ST_IDLE;
			default:            state_d = cht_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		req       = '0;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			cht_pkg::ST_CLEAR: begin
				req.bkt_we    = 1'b1;
				req.bkt_addr  = cht_pkg::BUCKET_BITS'(clr_q);
				req.used_we   = (int'(clr_q) < cht_pkg::USED_WORDS);
				req.used_addr = cht_pkg::UWA_BITS'(clr_q);
			end
			cht_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				req.bkt_re   = accept;
				req.bkt_addr = cht_pkg::bucket_of(in_item.key);
			end
			cht_pkg::ST_HEAD: begin
				req.node_re    = head_ptr[cht_pkg::NODE_BITS];
				req.node_raddr = head_ptr[cht_pkg::NODE_BITS-1:0];
				req.used_re    = 1'b1;
				req.used_addr  = hint_w;
			end
			cht_pkg::ST_NODE: begin
				req.node_re    = !hit && next_ptr[cht_pkg::NODE_BITS];
				req.node_raddr = next_ptr[cht_pkg::NODE_BITS-1:0];
				req.used_re    = 1'b1;
				req.used_addr  = hint_w;
			end
			cht_pkg::ST_SCAN: begin
				req.used_addr = free_found ? scan_w_q : scan_w_q + 1'b1;
				req.used_re   = !free_found;
				req.used_we   = free_found;
				req.used_wdata = rsp.used_rdata | (cht_pkg::UW'(1) << free_bit);
				req.key_we    = free_found;
				req.key_waddr = free_idx;
				req.key_wdata = key_q;
				req.nxt_we    = free_found;
				req.nxt_waddr = free_idx;
				req.nxt_wdata = '0;
			end
			cht_pkg::ST_LINK: begin
				req.nxt_we    = has_prev_q;
				req.nxt_waddr = prev_q;
				req.nxt_wdata = {1'b1, alloc_q};
				req.bkt_we    = !has_prev_q;
				req.bkt_addr  = bkt_q;
				req.bkt_wdata = {1'b1, alloc_q};
			end
			cht_pkg::ST_UNLINK: begin
				req.nxt_we    = has_prev_q;
				req.nxt_waddr = prev_q;
				req.nxt_wdata = nxt_q;
				req.bkt_we    = !has_prev_q;
				req.bkt_addr  = bkt_q;
				req.bkt_wdata = nxt_q;
				req.used_re   = 1'b1;
				req.used_addr = cur_w;
			end
			cht_pkg::ST_FREE: begin
				req.used_we    = 1'b1;
				req.used_addr  = cur_w;
				req.used_wdata = rsp.used_rdata & ~cur_bit;
			end
			cht_pkg::ST_RESP:  res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res_item = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cht_pkg::ST_CLEAR;
			clr_q      <= '0;
			count_q    <= '0;
			hint_q     <= '0;
			has_prev_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				cht_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				cht_pkg::ST_IDLE: begin
					if (accept) begin
						func_q     <= in_item.func;
						key_q      <= in_item.key;
						bkt_q      <= cht_pkg::bucket_of(in_item.key);
						has_prev_q <= 1'b0;
						res_q      <= '{status: cht_pkg::S_MISS, existed: 1'b0, handle: '0};
					end
				end
				cht_pkg::ST_HEAD: begin
					cur_q    <= head_ptr[cht_pkg::NODE_BITS-1:0];
					scan_w_q <= hint_w;
					if (!head_ptr[cht_pkg::NODE_BITS] && func_q == cht_pkg::F_INSERT && pool_full) begin
						res_q.status <= cht_pkg::S_FULL;
					end
				end
				cht_pkg::ST_NODE: begin
					scan_w_q <= hint_w;
					if (hit) begin
						res_q.status  <= cht_pkg::S_FOUND;
						res_q.existed <= (func_q == cht_pkg::F_INSERT);
						res_q.handle  <= cht_pkg::HANDLE_W'(cur_q);
						nxt_q         <= next_ptr;
					end else begin
						prev_q     <= cur_q;
						has_prev_q <= 1'b1;
						cur_q      <= next_ptr[cht_pkg::NODE_BITS-1:0];
						if (!next_ptr[cht_pkg::NODE_BITS] && func_q == cht_pkg::F_INSERT && pool_full) begin
							res_q.status <= cht_pkg::S_FULL;
						end
					end
				end
				cht_pkg::ST_SCAN: begin
					if (free_found) begin
						alloc_q      <= free_idx;
						res_q.status <= cht_pkg::S_NEW;
						res_q.handle <= cht_pkg::HANDLE_W'(free_idx);
						count_q      <= count_q + 1'b1;
						hint_q       <= cht_pkg::CNT_W'(free_idx) + 1'b1;
					end else begin
						scan_w_q <= scan_w_q + 1'b1;
					end
				end
				cht_pkg::ST_FREE: begin
					count_q <= count_q - 1'b1;
					if (cht_pkg::CNT_W'(cur_q) < hint_q) begin
						hint_q <= cht_pkg::CNT_W'(cur_q);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/chained_hash_table_unit.sv -----
// Chained hash table top level: sequencer, storage and the result register.
// Depends on cht_pkg, cht_mem, cht_seq.
//
//  channel | direction | payload            | handshake
//  in      | input     | cht_pkg::in_item_t  | in_valid / in_ready
//  out     | output    | cht_pkg::out_item_t | out_valid / out_ready
//
// Lookup/remove read the bucket head, then walk the chain node by node.
// Remove unlinks and frees the node; insert scans the bitmap for a new key.
// One item at a time; in_ready is high only while the sequencer is idle.
// After reset, a clearing pass over all bucket heads and used-bitmap words
// runs before the first beat is taken.
// A stalled result waits in the output register while the next beat is taken.
module chained_hash_table_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cht_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output cht_pkg::out_item_t out_item
);

	cht_pkg::mem_req_t  req;
	cht_pkg::mem_rsp_t  rsp;
	cht_pkg::out_item_t res_item;
	logic               res_valid, res_take, out_valid_q;
	cht_pkg::out_item_t out_q;

	assign res_take  = res_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	cht_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_item  (res_item),
		.req       (req),
		.rsp       (rsp)
	);

	cht_mem u_mem (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res_item;
		end
	end

endmodule

// ----- rtl/core/cht_checker.sv -----
// Port-level checks for the chained hash table top level, and its bind.
// Depends on cht_pkg and chained_hash_table_unit.
module cht_props (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input cht_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_ready,
	input cht_pkg::out_item_t out_item
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result beat changed while stalled");

	// one item in flight
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("beat taken while busy");

	a_existed_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.existed |-> out_item.status == cht_pkg::S_FOUND)
		else $error("existed set without found status");

	a_miss_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == cht_pkg::S_MISS ||
			out_item.status == cht_pkg::S_FULL) |-> out_item.handle == '0 && !out_item.existed)
		else $error("miss or full carries a handle");

endmodule

bind chained_hash_table_unit cht_props u_cht_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
